@@ sv/scf_pkg.sv @@
// Package for the strip cluster finder: register codes, reset values and the
// structs that travel between the configuration block, the partition tracker
// and the top level. Depends on nothing.
package scf_pkg;

  localparam int FIELD_W    = 7;   // width of strip numbers, sizes and lengths
  localparam int CFG_TIME_W = 16;  // width of the reference and window registers
  localparam int PC_W       = 3;   // width of the partition count register
  localparam int PC_MAX     = 7;   // largest partition count the register holds
  localparam int ADDR_W     = 4;   // APB byte address width
  localparam int DATA_W     = 32;  // APB data width

  localparam logic [FIELD_W-1:0] MAX_SIZE_RESET = 7'd96;
  localparam logic [PC_W-1:0]    PC_RESET       = 3'd3;
  localparam logic [FIELD_W-1:0] LEN_MAX        = 7'h7F;

  typedef enum logic [1:0] {
    REG_TRIG_REF   = 2'd0,
    REG_TIME_WIN   = 2'd1,
    REG_MAX_SIZE   = 2'd2,
    REG_PART_COUNT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] trigger_reference;
    logic [CFG_TIME_W-1:0] time_window;
    logic [FIELD_W-1:0]    max_cluster_size;
    logic [PC_W-1:0]       partition_count;
    logic                  pc_write;
  } cfg_t;

  typedef struct packed {
    logic in_part;
    logic last_in_part;
  } part_info_t;

endpackage

@@ sv/scf_intf.sv @@
// Handshake interfaces of the strip cluster finder: the strip request channel
// and the cluster result channel. Depends on scf_pkg.
interface scf_in_if #(
  parameter int TIME_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  logic                 strip_hit;
  logic [TIME_BITS-1:0] hit_time;
  logic                 event_end;

  modport source (output valid, strip_hit, hit_time, event_end, input ready);
  modport sink   (input valid, strip_hit, hit_time, event_end, output ready);
endinterface

interface scf_out_if ();
  logic                        valid;
  logic                        ready;
  logic [scf_pkg::FIELD_W-1:0] cluster_start;
  logic [scf_pkg::FIELD_W-1:0] cluster_size;

  modport source (output valid, cluster_start, cluster_size, input ready);
  modport sink   (input valid, cluster_start, cluster_size, output ready);
endinterface

@@ sv/scf_cfg_regs.sv @@
// APB register block of the strip cluster finder. Holds the four settings and
// flags a write of the partition count. Depends on scf_pkg.
module scf_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [scf_pkg::ADDR_W-1:0]     paddr,
  input  logic [scf_pkg::DATA_W-1:0]     pwdata,
  output logic [scf_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  output scf_pkg::cfg_t                  cfg_o
);
  import scf_pkg::*;

  logic [CFG_TIME_W-1:0] trig_q;
  logic [CFG_TIME_W-1:0] win_q;
  logic [FIELD_W-1:0]    max_size_q;
  logic [PC_W-1:0]       pc_q;
  logic                  wr_en;
  cfg_reg_e              reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_q     <= '0;
      win_q      <= '0;
      max_size_q <= MAX_SIZE_RESET;
      pc_q       <= PC_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_TRIG_REF:   trig_q     <= pwdata[CFG_TIME_W-1:0];
        REG_TIME_WIN:   win_q      <= pwdata[CFG_TIME_W-1:0];
        REG_MAX_SIZE:   max_size_q <= pwdata[FIELD_W-1:0];
        REG_PART_COUNT: pc_q       <= pwdata[PC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_TRIG_REF:   prdata = DATA_W'(trig_q);
      REG_TIME_WIN:   prdata = DATA_W'(win_q);
      REG_MAX_SIZE:   prdata = DATA_W'(max_size_q);
      REG_PART_COUNT: prdata = DATA_W'(pc_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.trigger_reference = trig_q;
  assign cfg_o.time_window       = win_q;
  assign cfg_o.max_cluster_size  = max_size_q;
  assign cfg_o.partition_count   = pc_q;
  // The cluster logic drops an open cluster at the same edge as this write.
  assign cfg_o.pc_write          = wr_en && (reg_sel == REG_PART_COUNT);

endmodule

@@ sv/scf_part_track.sv @@
// Partition tracker: one position and partition counter pair for each possible
// partition count, so no division is needed. Depends on scf_pkg.
module scf_part_track #(
  parameter int NUM_STRIPS = 96
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     advance_i,
  input  logic                     wrap_i,
  input  logic [scf_pkg::PC_W-1:0] pc_i,
  output scf_pkg::part_info_t      info_o
);
  import scf_pkg::*;

  localparam int IDX_W = $clog2(NUM_STRIPS);

  logic [PC_MAX:1]   in_part;
  logic [PC_MAX:1]   last_pos;
  logic [PC_W-1:0]   pc_eff;

  for (genvar k = 1; k <= PC_MAX; k++) begin : g_count
    localparam int PSIZE = (NUM_STRIPS / k > 0) ? NUM_STRIPS / k : 1;

    logic [IDX_W-1:0] pos_q;
    logic [PC_W-1:0]  part_q;

    assign last_pos[k] = (pos_q == IDX_W'(PSIZE - 1));
    assign in_part[k]  = (part_q < PC_W'(k));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pos_q  <= '0;
        part_q <= '0;
      end else if (advance_i) begin
        if (wrap_i) begin
          pos_q  <= '0;
          part_q <= '0;
        end else if (last_pos[k]) begin
          pos_q <= '0;
          if (part_q != PC_W'(PC_MAX)) begin
            part_q <= part_q + 1'b1;
          end
        end else begin
          pos_q <= pos_q + 1'b1;
        end
      end
    end
  end

  // A partition count of zero behaves as one.
  assign pc_eff = (pc_i == '0) ? PC_W'(1) : pc_i;

  assign info_o.in_part      = in_part[pc_eff];
  assign info_o.last_in_part = last_pos[pc_eff];

endmodule

@@ sv/strip_cluster_finder.sv @@
// Top level of the strip cluster finder: strip request channel in, cluster
// result channel out, APB settings. Depends on scf_pkg, scf_intf,
// scf_cfg_regs and scf_part_track.
//
// Usage: strips of an event are sent on in_if, one request per strip, in order
// from strip 1 up to NUM_STRIPS or up to the strip flagged with event_end.
// Each request carries the hit flag and the first hit time of the strip.
// Inside a run of consecutive hit strips within one partition, the first strip
// whose time lies within trigger_reference plus or minus time_window opens a
// cluster, which then extends to the end of the run. When the run ends, the
// cluster start and size appear on out_if, unless the size exceeds
// max_cluster_size.
// Latency: the result caused by a strip is shown on out_if in the cycle after
// that strip is accepted. Throughput: one strip per cycle while in_if is ready;
// the cluster logic and the partition counters update on each accepted strip.
// Stall: the result register frees when out_if is taken, and in_if stays ready
// in the cycle where a waiting result is taken; while a result waits and the
// receiver is not ready, in_if is held off.
// Reset: the strip counter restarts at strip 1, no cluster is open, the result
// register is empty and the settings take their reset values. Writing the
// partition count drops any open cluster without a result.
module strip_cluster_finder #(
  parameter int NUM_STRIPS = 96,
  parameter int TIME_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  scf_in_if.sink                     in_if,
  scf_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [scf_pkg::ADDR_W-1:0] paddr,
  input  logic [scf_pkg::DATA_W-1:0] pwdata,
  output logic [scf_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import scf_pkg::*;

  localparam int IDX_W = $clog2(NUM_STRIPS);
  localparam int TW    = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
  localparam int CW    = TW + 2;

  cfg_t        cfg;
  part_info_t  pinfo;

  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               open_q, open_d;
  logic [FIELD_W-1:0] start_q, start_d;
  logic [FIELD_W-1:0] len_q, len_d;
  logic               res_valid_q, res_valid_d;
  logic [FIELD_W-1:0] res_start_q, res_start_d;
  logic [FIELD_W-1:0] res_size_q, res_size_d;

  logic               fire;
  logic               last_strip;
  logic               wrap;
  logic               in_window;
  logic               emit;
  logic               ext_open;
  logic [FIELD_W-1:0] ext_start;
  logic [FIELD_W-1:0] ext_len;
  logic signed [CW-1:0] t_s, lo_s, hi_s;

  scf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scf_part_track #(
    .NUM_STRIPS (NUM_STRIPS)
  ) u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (fire),
    .wrap_i    (wrap),
    .pc_i      (cfg.partition_count),
    .info_o    (pinfo)
  );

  // The receiving side may take a waiting result in the same cycle.
  assign in_if.ready = !res_valid_q || out_if.ready;
  assign fire        = in_if.valid && in_if.ready;

  assign last_strip = (idx_q == IDX_W'(NUM_STRIPS - 1));
  assign wrap       = in_if.event_end || last_strip;

  // Signed window test; the lower bound may drop below zero.
  assign t_s  = $signed(CW'(in_if.hit_time));
  assign lo_s = $signed(CW'(cfg.trigger_reference)) - $signed(CW'(cfg.time_window));
  assign hi_s = $signed(CW'(cfg.trigger_reference)) + $signed(CW'(cfg.time_window));
  assign in_window = (t_s >= lo_s) && (t_s <= hi_s);

  // Cluster state after the current hit strip has been added.
  always_comb begin
    ext_open  = open_q;
    ext_start = start_q;
    ext_len   = len_q;
    if (open_q) begin
      if (len_q != LEN_MAX) begin
        ext_len = len_q + 1'b1;
      end
    end else if (in_window) begin
      ext_open  = 1'b1;
      ext_start = FIELD_W'(idx_q) + FIELD_W'(1);
      ext_len   = FIELD_W'(1);
    end
  end

  always_comb begin
    idx_d       = idx_q;
    open_d      = open_q;
    start_d     = start_q;
    len_d       = len_q;
    emit        = 1'b0;
    res_start_d = res_start_q;
    res_size_d  = res_size_q;

    if (fire) begin
      idx_d = wrap ? '0 : idx_q + 1'b1;
      if (!in_if.strip_hit || !pinfo.in_part) begin
        // The run ended before this strip.
        emit        = open_q && (len_q <= cfg.max_cluster_size);
        res_start_d = start_q;
        res_size_d  = len_q;
        open_d      = 1'b0;
        start_d     = '0;
        len_d       = '0;
      end else if (pinfo.last_in_part || wrap) begin
        // The run ends with this strip, which is counted.
        emit        = ext_open && (ext_len <= cfg.max_cluster_size);
        res_start_d = ext_start;
        res_size_d  = ext_len;
        open_d      = 1'b0;
        start_d     = '0;
        len_d       = '0;
      end else begin
        open_d  = ext_open;
        start_d = ext_start;
        len_d   = ext_len;
      end
    end

    if (cfg.pc_write) begin
      open_d  = 1'b0;
      start_d = '0;
      len_d   = '0;
    end

    if (fire) begin
      res_valid_d = emit;
    end else begin
      res_valid_d = res_valid_q && !out_if.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      open_q      <= 1'b0;
      start_q     <= '0;
      len_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      open_q      <= open_d;
      start_q     <= start_d;
      len_q       <= len_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && emit) begin
      res_start_q <= res_start_d;
      res_size_q  <= res_size_d;
    end
  end

  assign out_if.valid         = res_valid_q;
  assign out_if.cluster_start = res_start_q;
  assign out_if.cluster_size  = res_size_q;

`ifndef SYNTH
  a_open_has_length : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (len_q != '0))
    else $error("open cluster with zero length");

  a_idx_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_W'(NUM_STRIPS - 1))
    else $error("strip counter beyond last strip");

  a_no_spurious_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !in_if.strip_hit && !open_q) |=> !res_valid_q)
    else $error("result without an open cluster");

  a_result_nonzero_size : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && emit) |=> (res_size_q != '0))
    else $error("result with zero size");
`endif

endmodule
